>>> design/eucl_pkg.sv
// Shared widths, limits and stage type for the euclidean distance block.
package eucl_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_W  = 44;
  localparam int DIST_W = 21;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [ROOT_W-1:0] DIFF_LIMIT = {ROOT_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

endpackage

>>> design/eucl_acc.sv
// Difference, square and saturating accumulation front end.
module eucl_acc #(
  parameter int SAMPLE_WIDTH = eucl_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_take,
  input  logic [SAMPLE_WIDTH-1:0] a_sample,
  input  logic [SAMPLE_WIDTH-1:0] b_sample,
  input  logic                    last,
  output eucl_pkg::sqrt_stage_t   launch
);

  localparam int EXT_W = (SAMPLE_WIDTH > eucl_pkg::ROOT_W) ? SAMPLE_WIDTH : eucl_pkg::ROOT_W;

  logic                      v1_r, v1_nxt, last1_r;
  logic [SAMPLE_WIDTH-1:0]   mag_r, mag_nxt;
  logic                      v2_r, last2_r;
  logic [eucl_pkg::SUM_W-1:0] sq_r, sq_nxt;
  logic [eucl_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [eucl_pkg::SUM_W:0]   sum_wide;
  logic [SAMPLE_WIDTH:0]     diff;
  logic [SAMPLE_WIDTH:0]     diff_neg;
  logic [EXT_W-1:0]          mag_ext;
  logic [eucl_pkg::ROOT_W-1:0] mag_lo;
  eucl_pkg::sqrt_stage_t     launch_r, launch_nxt;

  assign v1_nxt   = in_take;
  assign diff     = {a_sample[SAMPLE_WIDTH-1], a_sample} - {b_sample[SAMPLE_WIDTH-1], b_sample};
  assign diff_neg = (SAMPLE_WIDTH + 1)'(0) - diff;
  assign mag_nxt  = diff[SAMPLE_WIDTH] ? diff_neg[SAMPLE_WIDTH-1:0] : diff[SAMPLE_WIDTH-1:0];

  assign mag_ext = EXT_W'(mag_r);
  assign mag_lo  = mag_ext[eucl_pkg::ROOT_W-1:0];

  always_comb begin
    if (mag_ext > EXT_W'(eucl_pkg::DIFF_LIMIT)) begin
      sq_nxt = eucl_pkg::SUM_MAX;
    end else begin
      sq_nxt = eucl_pkg::SUM_W'(mag_lo) * eucl_pkg::SUM_W'(mag_lo);
    end
  end

  assign sum_wide = {1'b0, sum_r} + {1'b0, sq_r};
  assign sum_nxt  = sum_wide[eucl_pkg::SUM_W] ? eucl_pkg::SUM_MAX
                                              : sum_wide[eucl_pkg::SUM_W-1:0];

  always_comb begin
    launch_nxt       = launch_r;
    launch_nxt.valid = v2_r && last2_r;
    launch_nxt.x     = sum_nxt;
    launch_nxt.rem   = '0;
    launch_nxt.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      sum_r          <= '0;
      launch_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r     <= v1_nxt;
      v2_r     <= v1_r;
      launch_r <= launch_nxt;
      if (v2_r) begin
        sum_r <= last2_r ? '0 : sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r   <= mag_nxt;
      last1_r <= last;
      sq_r    <= sq_nxt;
      last2_r <= last1_r;
    end
  end

  assign launch = launch_r;

  property p_sum_grows;
    @(posedge clk) disable iff (!rst_n)
      (adv && v2_r && !last2_r) |=> (sum_r >= $past(sum_r));
  endproperty
  a_sum_grows: assert property (p_sum_grows) else $error("sum decreased mid vector");

  property p_sum_clears;
    @(posedge clk) disable iff (!rst_n)
      (adv && v2_r && last2_r) |=> (sum_r == '0) && launch_r.valid;
  endproperty
  a_sum_clears: assert property (p_sum_clears) else $error("sum not cleared on last");

endmodule

>>> design/eucl_sqrt_cell.sv
// One restoring square root step, registered, in the root chain.
module eucl_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  eucl_pkg::sqrt_stage_t stage_i,
  output eucl_pkg::sqrt_stage_t stage_o
);

  eucl_pkg::sqrt_stage_t      stage_r, stage_nxt;
  logic [eucl_pkg::REM_W-1:0] rem_sh;
  logic [eucl_pkg::REM_W-1:0] trial;

  assign rem_sh = {stage_i.rem[eucl_pkg::REM_W-3:0],
                   stage_i.x[eucl_pkg::SUM_W-1:eucl_pkg::SUM_W-2]};
  assign trial  = {stage_i.root, 2'b01};

  always_comb begin
    stage_nxt       = stage_i;
    stage_nxt.x     = {stage_i.x[eucl_pkg::SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      stage_nxt.rem  = rem_sh - trial;
      stage_nxt.root = {stage_i.root[eucl_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      stage_nxt.rem  = rem_sh;
      stage_nxt.root = {stage_i.root[eucl_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

  property p_rem_bound;
    @(posedge clk) disable iff (!rst_n)
      stage_r.valid |-> ((eucl_pkg::REM_W + 1)'(stage_r.rem)
                         <= (eucl_pkg::REM_W + 1)'({stage_r.root, 1'b0}));
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("root remainder out of bound");

endmodule

>>> design/euclidean_distance.sv
// Top level of the streaming euclidean distance block.
// Usage:
//   The input channel carries one element pair per item: tdata holds a_sample
//   in the low SAMPLE_WIDTH bits and b_sample above it; tlast marks the final
//   pair of a vector. Each pair adds (a - b)^2 to a 44-bit saturating sum.
//   On the last pair the block emits one item on the output channel: the
//   floor square root of the sum, clamped to 21 bits, in input LSB units.
//   Throughput: one item per cycle unless stalled, vectors back to back with no gap.
//   Pipeline: an accepted last item passes three front stages (difference,
//   square, accumulate) and the chain of 22 square root cells, one result
//   bit per cell, then the output register, before out_tvalid.
//   Stall: while out_tvalid is high and out_tready low, every stage holds
//   and in_tready is low; nothing is lost or repeated.
//   Reset: rst_n low clears the sum and all stage valids; the block takes
//   items in the first cycle after reset.
module euclidean_distance #(
  parameter int SAMPLE_WIDTH = eucl_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         in_tdata,  // a_sample, b_sample
  input  logic                                        in_tlast,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [eucl_pkg::OUT_DATA_W-1:0]             out_tdata  // distance
);

  localparam int NUM_CELLS = eucl_pkg::ROOT_W;

  logic                            adv;
  logic                            in_take;
  logic                            out_tvalid_r;
  logic [eucl_pkg::DIST_W-1:0]     dist_r, dist_nxt;
  eucl_pkg::sqrt_stage_t           chain [NUM_CELLS+1];
  eucl_pkg::sqrt_stage_t           tail;

  assign adv       = !(out_tvalid_r && !out_tready);
  assign in_tready = adv;
  assign in_take   = in_tvalid && adv;

  eucl_acc #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_take  (in_take),
    .a_sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .b_sample (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .last     (in_tlast),
    .launch   (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    eucl_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign tail     = chain[NUM_CELLS];
  assign dist_nxt = tail.root[eucl_pkg::ROOT_W-1] ? eucl_pkg::DIST_MAX
                                                   : tail.root[eucl_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = eucl_pkg::OUT_DATA_W'(dist_r);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the streaming euclidean distance block.
class distance_scoreboard;
  logic [eucl_pkg::SUM_W-1:0]  sum_acc;
  logic [eucl_pkg::DIST_W-1:0] expected_q[$];
  int unsigned                 errors;
  int unsigned                 checked;
  int unsigned                 pairs;

  function new();
    sum_acc = '0;
    errors  = 0;
    checked = 0;
    pairs   = 0;
  endfunction

  // Floor square root of the sum, clamped to the output width.
  function automatic logic [eucl_pkg::DIST_W-1:0] floor_root(logic [eucl_pkg::SUM_W-1:0] s);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = 64'(s);
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (res > 64'(eucl_pkg::DIST_MAX)) return eucl_pkg::DIST_MAX;
    return res[eucl_pkg::DIST_W-1:0];
  endfunction

  function void note_pair(logic [15:0] a, logic [15:0] b, logic is_last);
    logic [16:0] diff;
    logic [16:0] mag;
    logic [63:0] sq;
    logic [63:0] total;
    pairs++;
    diff = {a[15], a} - {b[15], b};
    mag  = diff[16] ? 17'(-diff) : diff;
    if (64'(mag) > 64'(eucl_pkg::DIFF_LIMIT)) begin
      sum_acc = eucl_pkg::SUM_MAX;
    end else begin
      sq    = 64'(mag) * 64'(mag);
      total = 64'(sum_acc) + sq;
      sum_acc = (total > 64'(eucl_pkg::SUM_MAX)) ? eucl_pkg::SUM_MAX
                                                 : total[eucl_pkg::SUM_W-1:0];
    end
    if (is_last) begin
      expected_q.push_back(floor_root(sum_acc));
      sum_acc = '0;
    end
  endfunction

  function void check_distance(logic [eucl_pkg::DIST_W-1:0] distance);
    logic [eucl_pkg::DIST_W-1:0] exp_dist;
    if (expected_q.size() == 0) begin
      $error("distance: expected none, actual %0d", distance);
      errors++;
      return;
    end
    exp_dist = expected_q.pop_front();
    checked++;
    if (distance !== exp_dist) begin
      $error("distance: expected %0d, actual %0d", exp_dist, distance);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int TOTAL_PAIRS   = 1150;
  localparam int CLAMP_LEN     = 1030;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [eucl_pkg::OUT_DATA_W-1:0] out_tdata;

  distance_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned pairs_sent = 0;
  int unsigned vectors_sent = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  euclidean_distance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_distance(out_tdata[eucl_pkg::DIST_W-1:0]);
      if (in_tvalid && in_tready) sb.note_pair(in_tdata[15:0], in_tdata[31:16], in_tlast);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_request) begin
        out_tready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_request = 1'b0;
      end else begin
        out_tready <= !(rx_idle_en && $urandom_range(99) < 36);
      end
    end
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic is_last);
    while (tx_idle_en && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    pairs_sent++;
    if (is_last) vectors_sent++;
  endtask

  task automatic send_constant_vector(input logic [15:0] a, input logic [15:0] b, input int len);
    for (int i = 0; i < len; i++) send_pair(a, b, i == len - 1);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(7);
    case (sel)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_vector(input int max_len);
    int len;
    len = $urandom_range(max_len, 1);
    for (int i = 0; i < len; i++) send_pair(pick_sample(), pick_sample(), i == len - 1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single-element vectors at the extremes, then short known vectors
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h0003, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFC, 1'b1);
    send_pair(16'h0001, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'h0001, 1'b0);
    send_pair(16'h0002, 16'h0000, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    wait_for_results();

    // full-scale vector long enough that the root clamps, with no idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_constant_vector(16'h7FFF, 16'h8000, CLAMP_LEN);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_pair(16'h0001, 16'h0000, 1'b1);
    wait_for_results();

    // receiver holds off while short vectors keep coming
    hold_request = 1'b1;
    tx_idle_en = 1'b0;
    for (int v = 0; v < 20; v++) send_random_vector(3);
    tx_idle_en = 1'b1;
    wait_for_results();

    while (pairs_sent < TOTAL_PAIRS) send_random_vector(8);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d element pairs in %0d vectors, checked %0d distances.",
             pairs_sent, vectors_sent, sb.checked);
    $display("Covered extreme samples, a root clamped to the output width, and a long output stall.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/eucl_pkg.sv
design/eucl_acc.sv
design/eucl_sqrt_cell.sv
design/euclidean_distance.sv
tb/sv/tb.sv
